>>> rtl/core/wslt_pkg.sv
package wslt_pkg;

  localparam int NUM_CARS   = 5;
  localparam int TIME_BITS  = 16;

  localparam int REC_DEPTH  = 4 * NUM_CARS - 1;
  localparam int LAST_COUNT = 4 * NUM_CARS;
  localparam int CNT_W      = $clog2(LAST_COUNT + 1);
  localparam int SLOT_W     = $clog2(REC_DEPTH);

  localparam int SCALE_W    = 16;
  localparam int INTV_W     = 16;
  localparam int LEN_W      = 10;
  localparam int MULT_W     = 8;
  localparam int PROD_W     = SCALE_W + INTV_W;
  localparam int LPROD_W    = INTV_W + MULT_W;
  localparam int LSUM_W     = LPROD_W + 1;
  localparam int DIV_STEPS  = PROD_W;
  localparam int STEP_W     = $clog2(DIV_STEPS);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int S_DATA_W   = 16;
  localparam int M_DATA_W   = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_SCALE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOGIE_LEN      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VEHICLE_LEN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_LEN        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_MULT   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_OFFSET = 3'd6;

  localparam logic [SCALE_W-1:0] TRIGGER_SCALE_RST  = 16'd3348;
  localparam logic [LEN_W-1:0]   BOGIE_LEN_RST      = 10'd29;
  localparam logic [LEN_W-1:0]   VEHICLE_LEN_RST    = 10'd171;
  localparam logic [LEN_W-1:0]   GAP_LEN_RST        = 10'd60;
  localparam logic [15:0]        IDLE_TIMEOUT_RST   = 16'd17999;
  localparam logic [MULT_W-1:0]  TIMEOUT_MULT_RST   = 8'd90;
  localparam logic [15:0]        TIMEOUT_OFFSET_RST = 16'd5000;

  localparam logic [0:0] KIND_EDGE = 1'b0;
  localparam logic [0:0] KIND_TICK = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_DIV,
    ST_FIN,
    ST_DONE
  } state_t;

  // packed from the top bit down: line_period ends in the lowest bits
  typedef struct packed {
    logic        timed_out;
    logic        pass_done;
    logic        slot_written;
    logic [4:0]  slot_index;
    logic        camera_enable;
    logic        period_valid;
    logic [15:0] line_period;
  } res_t;

  localparam int RES_W = $bits(res_t);

endpackage

>>> rtl/core/wheel_speed_line_trigger.sv
// Wheel speed line trigger.
// Input stream: s_tuser is the item kind (wheel edge or timeout tick),
// s_tdata holds elapsed_ms of the edge. Output stream: one result item per
// input item on m_tdata. The user writes configuration registers through
// cfg_we/cfg_index/cfg_data only while no item is in flight; not enforced.
// A wheel edge that measures a segment writes its interval to the record
// memory, reads it back, multiplies by trigger_scale and runs a restoring
// divider, one quotient bit per cycle. s_tready returns in the same cycle
// as m_tvalid, so a new item is not taken while an edge is still being
// worked on. Timeout ticks and the first edge of a pass skip the
// arithmetic and go straight to the output stage.
// The result sits in an output register; the next item is accepted while it
// waits. When the receiver stalls, a second finished result waits in the
// block and s_tready stays low until the output register frees.
// rst is synchronous: edge count and timer clear, the timer runs, camera is
// off, the timeout limit and all configuration registers return to their
// defaults. The record memory is not cleared.
module wheel_speed_line_trigger
  import wslt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [S_DATA_W-1:0]   s_tdata,   // [15:0] elapsed_ms
  input  logic                  s_tuser,   // [0] kind
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [15:0] line_period, [16] period_valid, [17] camera_enable,
  // [22:18] slot_index, [23] slot_written, [24] pass_done, [25] timed_out
  output logic [M_DATA_W-1:0]   m_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [SCALE_W-1:0]   trigger_scale;
  logic [LEN_W-1:0]     bogie_len_mm;
  logic [LEN_W-1:0]     vehicle_len_mm;
  logic [LEN_W-1:0]     gap_len_mm;
  logic [15:0]          idle_timeout;
  logic [MULT_W-1:0]    timeout_mult;
  logic [15:0]          timeout_offset;

  state_t               state;
  state_t               state_next;

  logic [CNT_W-1:0]     edge_count;
  logic [TIME_BITS-1:0] timeout_count;
  logic [TIME_BITS-1:0] timeout_limit;
  logic                 timer_running;
  logic                 camera_on;

  logic [INTV_W-1:0]    segment_record [REC_DEPTH];
  logic [INTV_W-1:0]    rd_data;

  logic [SLOT_W-1:0]    slot;
  logic [LEN_W-1:0]     len;
  logic                 pass;
  res_t                 res;
  res_t                 res_next;
  res_t                 out_res;
  res_t                 out_res_next;

  logic [PROD_W-1:0]    div_q;
  logic [LEN_W-1:0]     div_rem;
  logic [STEP_W-1:0]    step;
  logic [LPROD_W-1:0]   lim_prod;

  logic                 accept;
  logic                 is_edge;
  logic [CNT_W-1:0]     count_inc;
  logic [CNT_W-1:0]     meas_off;
  logic [CNT_W-3:0]     car;
  logic [1:0]           pos_m1;
  logic                 edge_meas;
  logic                 edge_last;
  logic [SLOT_W-1:0]    slot_calc;
  logic [LEN_W-1:0]     len_sel;
  logic [LEN_W:0]       rem_sh;
  logic                 rem_ge;
  logic [LSUM_W-1:0]    lim_sum;
  logic [15:0]          period_calc;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign is_edge  = (s_tuser == KIND_EDGE);

  assign count_inc = (edge_count < CNT_W'(LAST_COUNT)) ? edge_count + CNT_W'(1) : edge_count;
  assign meas_off  = count_inc - CNT_W'(2);
  assign car       = meas_off[CNT_W-1:2];
  assign pos_m1    = meas_off[1:0];
  assign edge_meas = (count_inc >= CNT_W'(2));
  assign edge_last = edge_meas && (car == (CNT_W-2)'(NUM_CARS - 1)) && (pos_m1 == 2'd2);
  assign slot_calc = SLOT_W'(pos_m1) * SLOT_W'(NUM_CARS) + SLOT_W'(car);

  always_comb begin
    case (pos_m1)
      2'd1:    len_sel = vehicle_len_mm;
      2'd3:    len_sel = gap_len_mm;
      default: len_sel = bogie_len_mm;
    endcase
    if (len_sel == '0) begin
      len_sel = LEN_W'(1);
    end
  end

  assign rem_sh = {div_rem, div_q[PROD_W-1]};
  assign rem_ge = (rem_sh >= {1'b0, len});

  assign lim_sum = LSUM_W'(lim_prod) + LSUM_W'(timeout_offset);

  always_comb begin
    if (div_q == '0) begin
      period_calc = '0;
    end else if (div_q > PROD_W'(65536)) begin
      period_calc = 16'hFFFF;
    end else begin
      period_calc = 16'(div_q - PROD_W'(1));
    end
  end

  always_comb begin
    res_next = '0;
    if (is_edge) begin
      if (edge_meas) begin
        res_next.period_valid = 1'b1;
        res_next.slot_written = 1'b1;
        res_next.slot_index   = 5'(slot_calc);
        res_next.pass_done    = edge_last;
      end
    end else if (timer_running && (timeout_count >= timeout_limit)) begin
      res_next.timed_out = 1'b1;
    end
  end

  always_comb begin
    out_res_next               = res;
    out_res_next.camera_enable = camera_on;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (is_edge && edge_meas) ? ST_READ : ST_DONE;
        end
      end
      ST_READ: state_next = ST_MUL;
      ST_MUL:  state_next = ST_DIV;
      ST_DIV: begin
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN:  state_next = ST_DONE;
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_scale  <= TRIGGER_SCALE_RST;
      bogie_len_mm   <= BOGIE_LEN_RST;
      vehicle_len_mm <= VEHICLE_LEN_RST;
      gap_len_mm     <= GAP_LEN_RST;
      idle_timeout   <= IDLE_TIMEOUT_RST;
      timeout_mult   <= TIMEOUT_MULT_RST;
      timeout_offset <= TIMEOUT_OFFSET_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TRIGGER_SCALE:  trigger_scale  <= cfg_data;
        CFG_BOGIE_LEN:      bogie_len_mm   <= cfg_data[LEN_W-1:0];
        CFG_VEHICLE_LEN:    vehicle_len_mm <= cfg_data[LEN_W-1:0];
        CFG_GAP_LEN:        gap_len_mm     <= cfg_data[LEN_W-1:0];
        CFG_IDLE_TIMEOUT:   idle_timeout   <= cfg_data;
        CFG_TIMEOUT_MULT:   timeout_mult   <= cfg_data[MULT_W-1:0];
        CFG_TIMEOUT_OFFSET: timeout_offset <= cfg_data;
        default: ;
      endcase
    end
  end

  // record memory: written on acceptance, read back for the arithmetic
  always_ff @(posedge clk) begin
    if (accept && is_edge && edge_meas) begin
      segment_record[slot_calc] <= s_tdata[INTV_W-1:0];
    end
    if (state == ST_READ) begin
      rd_data <= segment_record[slot];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_count    <= '0;
      timeout_count <= '0;
      timeout_limit <= TIME_BITS'(IDLE_TIMEOUT_RST);
      timer_running <= 1'b1;
      camera_on     <= 1'b0;
    end else if (accept) begin
      if (is_edge) begin
        edge_count    <= edge_last ? '0 : count_inc;
        timeout_count <= '0;
        timer_running <= 1'b1;
        if (count_inc == CNT_W'(2)) begin
          camera_on <= 1'b1;
        end
      end else if (timer_running) begin
        if (timeout_count >= timeout_limit) begin
          timeout_count <= '0;
          timer_running <= 1'b0;
          edge_count    <= '0;
          camera_on     <= 1'b0;
          timeout_limit <= TIME_BITS'(idle_timeout);
        end else begin
          timeout_count <= timeout_count + TIME_BITS'(1);
        end
      end
    end else if (state == ST_FIN && pass) begin
      timeout_limit <= TIME_BITS'(lim_sum);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          res  <= res_next;
          slot <= slot_calc;
          len  <= len_sel;
          pass <= is_edge && edge_last;
        end
      end
      ST_MUL: begin
        div_q    <= PROD_W'(trigger_scale) * PROD_W'(rd_data);
        lim_prod <= LPROD_W'(rd_data) * LPROD_W'(timeout_mult);
        div_rem  <= '0;
        step     <= '0;
      end
      ST_DIV: begin
        div_q   <= {div_q[PROD_W-2:0], rem_ge};
        div_rem <= rem_ge ? LEN_W'(rem_sh - {1'b0, len}) : rem_sh[LEN_W-1:0];
        step    <= step + STEP_W'(1);
      end
      ST_FIN: begin
        res.line_period <= period_calc;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DONE && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!m_tvalid || m_tready)) begin
      out_res <= out_res_next;
    end
  end

  assign m_tdata = {{(M_DATA_W - RES_W){1'b0}}, out_res};

endmodule

>>> rtl/core/wslt_checker.sv
module wslt_checker
  import wslt_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [M_DATA_W-1:0] m_tdata
);

  res_t r;

  assign r = res_t'(m_tdata[RES_W-1:0]);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result shown right after reset");

  a_slot_period: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (r.period_valid == r.slot_written) &&
                 (r.slot_written || r.slot_index == '0))
    else $error("slot and period flags disagree");

  a_timeout_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && r.timed_out |-> !r.camera_enable && !r.period_valid &&
                                !r.pass_done)
    else $error("timeout item carries edge results");

  a_pass_period: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && r.pass_done |-> r.period_valid && r.camera_enable)
    else $error("pass done without a measured segment");

endmodule

bind wheel_speed_line_trigger wslt_checker u_wslt_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
